### rtl/core/bmr_pkg.sv
// Shared constants, register indexes and control bundles of the mip level reduction block.
package bmr_pkg;

	localparam int MAX_WIDTH    = 2048;
	localparam int MAX_HEIGHT   = 4096;
	localparam int MAX_CHANNELS = 4;
	localparam int NUM_LANES    = 4;

	localparam int TEXEL_W    = 16;
	localparam int PAIR_W     = TEXEL_W + 1;
	localparam int SUM_W      = TEXEL_W + 2;
	localparam int WIDTH_W    = 12;
	localparam int HEIGHT_W   = 13;
	localparam int CHAN_W     = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int LINE_DEPTH = MAX_WIDTH / 2;
	localparam int LINE_AW    = $clog2(LINE_DEPTH);
	localparam int OY_W       = ROW_W - 1;

	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNELS   = 2'd2;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET    = WIDTH_W'(1024);
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET   = HEIGHT_W'(1024);
	localparam logic [CHAN_W-1:0]   CHANNELS_RESET = CHAN_W'(MAX_CHANNELS);

	typedef struct packed {
		logic               load_hold;
		logic               w_one;
		logic               line_wr;
		logic               line_rd;
		logic [LINE_AW-1:0] addr;
		logic               capture;
		logic               self_up_s1;
	} lane_ctl_t;

	typedef struct packed {
		logic s1_valid;
		logic last_s1;
		logic adv;
	} merge_ctl_t;

endpackage

### rtl/core/bmr_in_if.sv
// Source texel channel: valid/ready handshake with four channel values.
interface bmr_in_if;
	logic                         valid;
	logic                         ready;
	logic [bmr_pkg::TEXEL_W-1:0]  texel_c0;
	logic [bmr_pkg::TEXEL_W-1:0]  texel_c1;
	logic [bmr_pkg::TEXEL_W-1:0]  texel_c2;
	logic [bmr_pkg::TEXEL_W-1:0]  texel_c3;

	modport source (output valid, texel_c0, texel_c1, texel_c2, texel_c3, input ready);
	modport sink   (input valid, texel_c0, texel_c1, texel_c2, texel_c3, output ready);
endinterface

### rtl/core/bmr_out_if.sv
// Reduced texel channel: valid/ready handshake with averages and end-of-level flag.
interface bmr_out_if;
	logic                         valid;
	logic                         ready;
	logic [bmr_pkg::TEXEL_W-1:0]  avg_c0;
	logic [bmr_pkg::TEXEL_W-1:0]  avg_c1;
	logic [bmr_pkg::TEXEL_W-1:0]  avg_c2;
	logic [bmr_pkg::TEXEL_W-1:0]  avg_c3;
	logic                         level_done;

	modport source (output valid, avg_c0, avg_c1, avg_c2, avg_c3, level_done, input ready);
	modport sink   (input valid, avg_c0, avg_c1, avg_c2, avg_c3, level_done, output ready);
endinterface

### rtl/core/box_mipmap_reduction.sv
// Top level of the 2x2 box-filter mip level reduction block.
// Usage:
//   src  - source texels in raster order, four 16-bit unorm channels per transaction.
//   dst  - reduced texels in raster order; level_done marks the last texel of the
//          reduced level. Channels at or above channels_in_use read as zero.
//   cfg_* - register writes (src_width, src_height, channels_in_use); write only
//          while idle. Writing a dimension restarts the level at its first texel.
// Throughput: one texel per cycle unless dst stalls. Each channel has its own lane
//   with a line store of 1024 upper-row pair sums (one write and one read port),
//   so the lanes and the line stores keep pace with one transaction a cycle.
// Pipeline: a transaction that completes a 2x2 block passes through one pipeline stage
//   for the line read and then the output register before it shows on dst.
// Texels that complete no block produce no transaction. A 1x1 source gives none.
// Reset: clears the raster position and all valid flags and loads the register
//   defaults (1024 by 1024, four channels); the line stores need no clearing.
// Stall: when dst is stalled, the output holds; one more result waits in the
//   pipeline stage, and src is held off only once both are full.
module box_mipmap_reduction (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [bmr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bmr_pkg::CFG_DATA_W-1:0] cfg_data,
	bmr_in_if.sink                         src,
	bmr_out_if.source                      dst
);

	bmr_pkg::lane_ctl_t                                  lane_ctl;
	bmr_pkg::merge_ctl_t                                 merge_ctl;
	logic [bmr_pkg::CHAN_W-1:0]                          nch;
	logic [bmr_pkg::NUM_LANES-1:0][bmr_pkg::TEXEL_W-1:0] texel;
	logic [bmr_pkg::NUM_LANES-1:0][bmr_pkg::TEXEL_W-1:0] lane_avg;

	// Gather the channel fields so the lanes can be generated
	assign texel[0] = src.texel_c0;
	assign texel[1] = src.texel_c1;
	assign texel[2] = src.texel_c2;
	assign texel[3] = src.texel_c3;

	bmr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.src_valid (src.valid),
		.src_ready (src.ready),
		.dst_valid (dst.valid),
		.dst_ready (dst.ready),
		.lane_ctl  (lane_ctl),
		.merge_ctl (merge_ctl),
		.nch       (nch)
	);

	// One lane per channel, all driven by the same raster control
	for (genvar c = 0; c < bmr_pkg::NUM_LANES; c++) begin : g_lane
		bmr_lane u_lane (
			.clk   (clk),
			.texel (texel[c]),
			.ctl   (lane_ctl),
			.avg   (lane_avg[c])
		);
	end

	bmr_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.lane_avg (lane_avg),
		.nch      (nch),
		.ctl      (merge_ctl),
		.dst      (dst)
	);

endmodule

### rtl/core/bmr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bmr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/core/bmr_ctrl.sv
// Raster position, configuration registers and handshake control of the reduction block.
module bmr_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [bmr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bmr_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              src_valid,
	output logic                              src_ready,
	input  logic                              dst_valid,
	input  logic                              dst_ready,
	output bmr_pkg::lane_ctl_t                lane_ctl,
	output bmr_pkg::merge_ctl_t               merge_ctl,
	output logic [bmr_pkg::CHAN_W-1:0]        nch
);

	logic [bmr_pkg::WIDTH_W-1:0]  width_q;
	logic [bmr_pkg::HEIGHT_W-1:0] height_q;
	logic [bmr_pkg::CHAN_W-1:0]   nch_q;
	logic [bmr_pkg::COL_W-1:0]    col_q;
	logic [bmr_pkg::ROW_W-1:0]    row_q;
	logic                         s1_valid_q;
	logic                         last_s1;
	logic                         self_up_s1;

	logic                         w_one, h_one, have_pair, emit, accept, adv;
	logic                         col_end, row_end, last_x, last_y;
	logic [bmr_pkg::LINE_AW-1:0]  ox;
	logic [bmr_pkg::OY_W-1:0]     oy;
	logic [bmr_pkg::COL_W-1:0]    half_w;
	logic [bmr_pkg::ROW_W-1:0]    half_h;
	logic [bmr_pkg::WIDTH_W-1:0]  sat_w;
	logic [bmr_pkg::HEIGHT_W-1:0] sat_h;
	logic [bmr_pkg::CHAN_W-1:0]   sat_c;

	// Clamp register writes into their legal ranges
	always_comb begin
		sat_w = cfg_data[bmr_pkg::WIDTH_W-1:0];
		if (sat_w == '0) begin
			sat_w = bmr_pkg::WIDTH_W'(1);
		end else if (sat_w > bmr_pkg::WIDTH_W'(bmr_pkg::MAX_WIDTH)) begin
			sat_w = bmr_pkg::WIDTH_W'(bmr_pkg::MAX_WIDTH);
		end
		sat_h = cfg_data[bmr_pkg::HEIGHT_W-1:0];
		if (sat_h == '0) begin
			sat_h = bmr_pkg::HEIGHT_W'(1);
		end else if (sat_h > bmr_pkg::HEIGHT_W'(bmr_pkg::MAX_HEIGHT)) begin
			sat_h = bmr_pkg::HEIGHT_W'(bmr_pkg::MAX_HEIGHT);
		end
		sat_c = cfg_data[bmr_pkg::CHAN_W-1:0];
		if (sat_c == '0) begin
			sat_c = bmr_pkg::CHAN_W'(1);
		end else if (sat_c > bmr_pkg::CHAN_W'(bmr_pkg::MAX_CHANNELS)) begin
			sat_c = bmr_pkg::CHAN_W'(bmr_pkg::MAX_CHANNELS);
		end
	end

	assign w_one     = (width_q == bmr_pkg::WIDTH_W'(1));
	assign h_one     = (height_q == bmr_pkg::HEIGHT_W'(1));
	assign have_pair = w_one || col_q[0];
	assign emit      = have_pair && (h_one ? !w_one : row_q[0]);
	assign ox        = w_one ? '0 : col_q[bmr_pkg::COL_W-1:1];
	assign oy        = h_one ? '0 : row_q[bmr_pkg::ROW_W-1:1];

	assign half_w = width_q[bmr_pkg::WIDTH_W-1:1];
	assign half_h = height_q[bmr_pkg::HEIGHT_W-1:1];
	assign last_x = ({1'b0, ox} + bmr_pkg::COL_W'(1)) ==
		((half_w == '0) ? bmr_pkg::COL_W'(1) : half_w);
	assign last_y = ({1'b0, oy} + bmr_pkg::ROW_W'(1)) ==
		((half_h == '0) ? bmr_pkg::ROW_W'(1) : half_h);

	assign col_end = ({1'b0, col_q} + bmr_pkg::WIDTH_W'(1)) == width_q;
	assign row_end = ({1'b0, row_q} + bmr_pkg::HEIGHT_W'(1)) == height_q;

	assign adv       = !dst_valid || dst_ready;
	assign src_ready = !s1_valid_q || adv;
	assign accept    = src_valid && src_ready;

	always_comb begin
		lane_ctl.load_hold  = accept && !w_one && !col_q[0];
		lane_ctl.w_one      = w_one;
		lane_ctl.line_wr    = accept && have_pair && !h_one && !row_q[0];
		lane_ctl.line_rd    = accept && have_pair && !h_one && row_q[0];
		lane_ctl.addr       = ox;
		lane_ctl.capture    = accept;
		lane_ctl.self_up_s1 = self_up_s1;
		merge_ctl.s1_valid  = s1_valid_q;
		merge_ctl.last_s1   = last_s1;
		merge_ctl.adv       = adv;
	end

	assign nch = nch_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= bmr_pkg::WIDTH_RESET;
			height_q   <= bmr_pkg::HEIGHT_RESET;
			nch_q      <= bmr_pkg::CHANNELS_RESET;
			col_q      <= '0;
			row_q      <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					bmr_pkg::REG_SRC_WIDTH: begin
						width_q <= sat_w;
						col_q   <= '0;
						row_q   <= '0;
					end
					bmr_pkg::REG_SRC_HEIGHT: begin
						height_q <= sat_h;
						col_q    <= '0;
						row_q    <= '0;
					end
					bmr_pkg::REG_CHANNELS: begin
						nch_q <= sat_c;
					end
					default: begin
					end
				endcase
			end else if (accept) begin
				if (col_end) begin
					col_q <= '0;
					row_q <= row_end ? '0 : row_q + bmr_pkg::ROW_W'(1);
				end else begin
					col_q <= col_q + bmr_pkg::COL_W'(1);
				end
			end
			if (src_ready) begin
				s1_valid_q <= accept && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1    <= last_x && last_y;
			self_up_s1 <= h_one;
		end
	end

endmodule

### rtl/core/bmr_lane.sv
// One channel lane: horizontal pair, line store of upper pair sums, 2x2 average.
module bmr_lane (
	input  logic                          clk,
	input  logic [bmr_pkg::TEXEL_W-1:0]   texel,
	input  bmr_pkg::lane_ctl_t            ctl,
	output logic [bmr_pkg::TEXEL_W-1:0]   avg
);

	logic [bmr_pkg::TEXEL_W-1:0] hold_q;
	logic [bmr_pkg::PAIR_W-1:0]  pair;
	logic [bmr_pkg::PAIR_W-1:0]  pair_s1;
	logic [bmr_pkg::PAIR_W-1:0]  up_rd;
	logic [bmr_pkg::SUM_W-1:0]   sum;

	// A one-texel-wide source pairs each texel with itself
	assign pair = ctl.w_one ? {texel, 1'b0} : ({1'b0, hold_q} + {1'b0, texel});

	always_ff @(posedge clk) begin
		if (ctl.load_hold) begin
			hold_q <= texel;
		end
		if (ctl.capture) begin
			pair_s1 <= pair;
		end
	end

	bmr_ram #(
		.WIDTH (bmr_pkg::PAIR_W),
		.DEPTH (bmr_pkg::LINE_DEPTH)
	) u_line (
		.clk     (clk),
		.wr_en   (ctl.line_wr),
		.wr_addr (ctl.addr),
		.wr_data (pair),
		.rd_en   (ctl.line_rd),
		.rd_addr (ctl.addr),
		.rd_data (up_rd)
	);

	// A one-row source uses the same pair as its upper neighbour
	assign sum = {1'b0, pair_s1} + {1'b0, (ctl.self_up_s1 ? pair_s1 : up_rd)};
	assign avg = sum[bmr_pkg::SUM_W-1:2];

endmodule

### rtl/core/bmr_merge.sv
// Output register: gathers lane averages, masks unused channels, flags end of level.
module bmr_merge (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  logic [bmr_pkg::NUM_LANES-1:0][bmr_pkg::TEXEL_W-1:0] lane_avg,
	input  logic [bmr_pkg::CHAN_W-1:0]                          nch,
	input  bmr_pkg::merge_ctl_t                                 ctl,
	bmr_out_if.source                                           dst
);

	logic                                               valid_q;
	logic [bmr_pkg::NUM_LANES-1:0][bmr_pkg::TEXEL_W-1:0] avg_q;
	logic                                               done_q;
	logic [bmr_pkg::NUM_LANES-1:0][bmr_pkg::TEXEL_W-1:0] masked;

	always_comb begin
		for (int c = 0; c < bmr_pkg::NUM_LANES; c++) begin
			masked[c] = (bmr_pkg::CHAN_W'(c) < nch) ? lane_avg[c] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.adv) begin
			valid_q <= ctl.s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv && ctl.s1_valid) begin
			avg_q  <= masked;
			done_q <= ctl.last_s1;
		end
	end

	assign dst.valid      = valid_q;
	assign dst.avg_c0     = avg_q[0];
	assign dst.avg_c1     = avg_q[1];
	assign dst.avg_c2     = avg_q[2];
	assign dst.avg_c3     = avg_q[3];
	assign dst.level_done = done_q;

endmodule

### rtl/core/bmr_chk.sv
// Port-level checker for the reduction block, bound to the top level.
module bmr_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          src_valid,
	input logic                          src_ready,
	input logic                          dst_valid,
	input logic                          dst_ready,
	input logic [bmr_pkg::TEXEL_W-1:0]   avg_c0,
	input logic                          level_done
);

	// A stalled result holds
	a_dst_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_ready |=> dst_valid && $stable(avg_c0) && $stable(level_done))
		else $error("stalled dst transaction changed");

	// src is held off only while a result waits on a stalled dst
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!src_ready |-> dst_valid && !dst_ready)
		else $error("src held off without dst stall");

	// A fresh result follows a src transaction through the pipeline stage and the output register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dst_valid) |-> $past(src_valid && src_ready, 2))
		else $error("dst transaction without source transaction");

endmodule

bind box_mipmap_reduction bmr_chk u_bmr_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.src_valid  (src.valid),
	.src_ready  (src.ready),
	.dst_valid  (dst.valid),
	.dst_ready  (dst.ready),
	.avg_c0     (dst.avg_c0),
	.level_done (dst.level_done)
);
